@@ rtl/sfu_pkg.sv @@
// Shared constants, types and arithmetic helpers for the steering force frame update core.
package sfu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ITER_STEPS = 32;

  localparam logic [30:0] MIN_DUR = 31'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);
  localparam logic [63:0] V2_EPS = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
  localparam logic [17:0] HEAD_ONE = 18'(64'd1 << FRAC_BITS);

  localparam logic [30:0] MAX_FORCE_RST = 31'd655360;
  localparam logic [30:0] MAX_SPEED_RST = 31'd6553600;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_TFORCE = 2'd1,
    CMD_TIMP   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_MAX_FORCE = 2'd1,
    REG_MAX_SPEED = 2'd2
  } reg_idx_t;

  // request to the shared divide / square-root unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_req_t;

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  // clamp a magnitude to 2^31, apply the sign, saturate to 32 bits signed
  function automatic logic [31:0] sign_sat(logic [63:0] q, logic neg);
    logic [31:0] qc;
    qc = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
    if (neg) return 32'(-qc);
    if (qc == 32'h8000_0000) return 32'h7FFF_FFFF;
    return qc;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

endpackage

@@ rtl/steering_force_frame_update_core.sv @@
// Top level: steering force frame update sequencer around one multiplier and one divide/root unit.
// Contribution, timed-force and timed-impulse words are taken in the idle state and stay in it.
// A tick word runs two square roots and up to eight divides, plus multiplier and sequencer
// steps, before the next word is taken.
// The next word is taken while a result waits; a second finished tick holds until out_ready.
// Synchronous active-high reset: registers to defaults, state cleared, heading to unit x.
module steering_force_frame_update_core import sfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic [30:0] time_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] impulse_x,
  output logic signed [31:0] impulse_y,
  output logic        impulse_active,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic        vel_clamped,
  output logic signed [17:0] heading_x,
  output logic signed [17:0] heading_y
);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_TF_MUL   = 15'b000000000000010,
    ST_TF_DIV   = 15'b000000000000100,
    ST_MAG_X    = 15'b000000000001000,
    ST_MAG_Y    = 15'b000000000010000,
    ST_MAG_LIM  = 15'b000000000100000,
    ST_MAG_CMP  = 15'b000000001000000,
    ST_SQRT     = 15'b000000010000000,
    ST_HEAD_DIV = 15'b000000100000000,
    ST_SCL_MUL  = 15'b000001000000000,
    ST_SCL_DIV  = 15'b000010000000000,
    ST_LIM_END  = 15'b000100000000000,
    ST_IMP_MUL  = 15'b001000000000000,
    ST_IMP_FIN  = 15'b010000000000000,
    ST_DONE     = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic        enable;
  logic [30:0] max_force;
  logic [30:0] max_speed;

  // architectural state
  logic [31:0] accum_x, accum_y;
  logic [31:0] tf_x, tf_y;
  logic [30:0] tf_dur, tf_left;
  logic [31:0] ir_x, ir_y;
  logic [30:0] imp_left;
  logic [17:0] head_x, head_y;

  // tick working registers
  logic [31:0] wx, wy;         // vector under the current limit pass
  logic [31:0] vin_x, vin_y;   // body velocity of the tick
  logic [30:0] tv;
  logic [31:0] frc_x, frc_y;
  logic [31:0] imp_x, imp_y;
  logic        iact;
  logic [63:0] mag;
  logic [63:0] prod;
  logic [31:0] len;
  logic        over;
  logic        hvalid;
  logic        axis;            // 0 works on x, 1 on y
  logic        pass;            // 0 force limit, 1 velocity limit
  logic        started;         // divide/root request issued in this state

  // shared datapath
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] w_sel, tf_sel, ir_sel;
  logic [30:0] lim, slice;
  logic        div_neg;
  logic [31:0] div_val, imp_val;
  iter_req_t   iter_req;
  logic [63:0] iter_num;
  logic [31:0] iter_den;
  logic        iter_done;
  logic [31:0] iter_res;
  logic        iter_state;
  logic        take_out;

  assign w_sel  = axis ? wy : wx;
  assign tf_sel = axis ? tf_y : tf_x;
  assign ir_sel = axis ? ir_y : ir_x;
  assign lim    = pass ? max_speed : max_force;
  assign slice  = (tv < imp_left) ? tv : imp_left;

  // operand select for the single 32x32 multiplier
  always_comb begin
    case (state)
      ST_TF_MUL: begin
        mul_a = abs32(tf_sel);
        mul_b = {1'b0, tf_left};
      end
      ST_MAG_X: begin
        mul_a = abs32(wx);
        mul_b = abs32(wx);
      end
      ST_MAG_Y: begin
        mul_a = abs32(wy);
        mul_b = abs32(wy);
      end
      ST_MAG_LIM: begin
        mul_a = {1'b0, lim};
        mul_b = {1'b0, lim};
      end
      ST_SCL_MUL: begin
        mul_a = abs32(w_sel);
        mul_b = {1'b0, lim};
      end
      ST_IMP_MUL: begin
        mul_a = abs32(ir_sel);
        mul_b = {1'b0, slice};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // divide/root request: numerator and divisor by state
  always_comb begin
    iter_state = (state == ST_TF_DIV) || (state == ST_SQRT) ||
                 (state == ST_HEAD_DIV) || (state == ST_SCL_DIV);
    iter_req.start   = iter_state && !started;
    iter_req.is_sqrt = (state == ST_SQRT);
    case (state)
      ST_TF_DIV: begin
        iter_num = prod;
        iter_den = {1'b0, tf_dur};
      end
      ST_SQRT: begin
        iter_num = mag;
        iter_den = '0;
      end
      ST_HEAD_DIV: begin
        iter_num = {32'd0, abs32(w_sel)} << FRAC_BITS;
        iter_den = len;
      end
      ST_SCL_DIV: begin
        iter_num = prod;
        iter_den = len;
      end
      default: begin
        iter_num = '0;
        iter_den = '0;
      end
    endcase
  end

  sfu_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (iter_req),
    .num  (iter_num),
    .den  (iter_den),
    .done (iter_done),
    .res  (iter_res)
  );

  assign div_neg = (state == ST_TF_DIV) ? tf_sel[31] : w_sel[31];
  assign div_val = sign_sat({32'd0, iter_res}, div_neg);
  assign imp_val = sign_sat(prod >> FRAC_BITS, ir_sel[31]);

  assign in_ready = (state == ST_IDLE);
  assign take_out = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      max_force <= MAX_FORCE_RST;
      max_speed <= MAX_SPEED_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_MAX_FORCE: max_force <= cfg_data;
        REG_MAX_SPEED: max_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // free-running product register
  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
      accum_x   <= '0;
      accum_y   <= '0;
      tf_x      <= '0;
      tf_y      <= '0;
      tf_dur    <= MIN_DUR;
      tf_left   <= '0;
      ir_x      <= '0;
      ir_y      <= '0;
      imp_left  <= '0;
      head_x    <= HEAD_ONE;
      head_y    <= '0;
    end else begin
      // load a new word or drop the one just taken
      if ((state == ST_DONE) && take_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (cmd_t'(cmd))
              CMD_ADD: begin
                accum_x <= sat_add(accum_x, vec_x);
                accum_y <= sat_add(accum_y, vec_y);
              end
              CMD_TFORCE: begin
                tf_x    <= vec_x;
                tf_y    <= vec_y;
                tf_dur  <= (time_value < MIN_DUR) ? MIN_DUR : time_value;
                tf_left <= (time_value < MIN_DUR) ? MIN_DUR : time_value;
              end
              CMD_TIMP: begin
                ir_x     <= vec_x;
                ir_y     <= vec_y;
                imp_left <= (time_value < MIN_DUR) ? MIN_DUR : time_value;
              end
              CMD_TICK: begin
                // disabled: drop the tick
                if (enable) begin
                  wx      <= accum_x;
                  wy      <= accum_y;
                  accum_x <= '0;
                  accum_y <= '0;
                  vin_x   <= vec_x;
                  vin_y   <= vec_y;
                  tv      <= time_value;
                  pass    <= 1'b0;
                  axis    <= 1'b0;
                  iact    <= 1'b0;
                  imp_x   <= '0;
                  imp_y   <= '0;
                  state   <= (tf_left != '0) ? ST_TF_MUL : ST_MAG_X;
                end
              end
              default: ;
            endcase
          end
        end
        ST_TF_MUL: state <= ST_TF_DIV;
        ST_TF_DIV: begin
          if (!started) begin
            started <= 1'b1;
          end else if (iter_done) begin
            started <= 1'b0;
            // add the decaying timed force share
            if (axis) begin
              wy      <= sat_add(wy, div_val);
              axis    <= 1'b0;
              tf_left <= (tf_left > tv) ? tf_left - tv : '0;
              state   <= ST_MAG_X;
            end else begin
              wx    <= sat_add(wx, div_val);
              axis  <= 1'b1;
              state <= ST_TF_MUL;
            end
          end
        end
        ST_MAG_X:   state <= ST_MAG_Y;
        ST_MAG_Y: begin
          mag   <= prod;
          state <= ST_MAG_LIM;
        end
        ST_MAG_LIM: begin
          mag   <= mag + prod;
          state <= ST_MAG_CMP;
        end
        ST_MAG_CMP: begin
          over   <= mag > prod;
          hvalid <= pass && (mag > V2_EPS);
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (!started) begin
            started <= 1'b1;
          end else if (iter_done) begin
            started <= 1'b0;
            len     <= iter_res;
            axis    <= 1'b0;
            if (hvalid)    state <= ST_HEAD_DIV;
            else if (over) state <= ST_SCL_MUL;
            else           state <= ST_LIM_END;
          end
        end
        ST_HEAD_DIV: begin
          if (!started) begin
            started <= 1'b1;
          end else if (iter_done) begin
            started <= 1'b0;
            if (axis) begin
              head_y <= div_val[17:0];
              axis   <= 1'b0;
              state  <= over ? ST_SCL_MUL : ST_LIM_END;
            end else begin
              head_x <= div_val[17:0];
              axis   <= 1'b1;
            end
          end
        end
        ST_SCL_MUL: state <= ST_SCL_DIV;
        ST_SCL_DIV: begin
          if (!started) begin
            started <= 1'b1;
          end else if (iter_done) begin
            started <= 1'b0;
            if (axis) begin
              wy    <= div_val;
              axis  <= 1'b0;
              state <= ST_LIM_END;
            end else begin
              wx    <= div_val;
              axis  <= 1'b1;
              state <= ST_SCL_MUL;
            end
          end
        end
        ST_LIM_END: begin
          if (!pass) begin
            // hold the limited force, move on to the impulse and the velocity
            frc_x <= wx;
            frc_y <= wy;
            wx    <= vin_x;
            wy    <= vin_y;
            pass  <= 1'b1;
            state <= (imp_left != '0) ? ST_IMP_MUL : ST_MAG_X;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_IMP_MUL: state <= ST_IMP_FIN;
        ST_IMP_FIN: begin
          if (axis) begin
            imp_y    <= imp_val;
            iact     <= 1'b1;
            axis     <= 1'b0;
            imp_left <= (imp_left > tv) ? imp_left - tv : '0;
            state    <= ST_MAG_X;
          end else begin
            imp_x <= imp_val;
            axis  <= 1'b1;
            state <= ST_IMP_MUL;
          end
        end
        ST_DONE: begin
          if (take_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && take_out) begin
      force_x        <= frc_x;
      force_y        <= frc_y;
      impulse_x      <= imp_x;
      impulse_y      <= imp_y;
      impulse_active <= iact;
      vel_x          <= wx;
      vel_y          <= wy;
      vel_clamped    <= over;
      heading_x      <= head_x;
      heading_y      <= head_y;
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE))
    else $error("result overwritten while the previous word waits");

  a_iter_owned: assert property (@(posedge clk) disable iff (rst)
    iter_done |-> (started && iter_state))
    else $error("divide/root result with no request pending");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(head_x) <= $signed(HEAD_ONE)) && ($signed(head_x) >= -$signed(HEAD_ONE)))
    else $error("heading x out of unit range");

endmodule

@@ rtl/sfu_iter.sv @@
// Shared iterative unit: 64/32 unsigned divide or 64-bit integer square root, one bit a cycle.
module sfu_iter import sfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_req_t   req,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] res
);

  logic        busy;
  logic        mode_sqrt;
  logic [5:0]  cnt;
  logic [34:0] rem;
  logic [63:0] work;
  logic [31:0] q;
  logic [31:0] den_r;
  logic [34:0] op_a;
  logic [34:0] op_b;
  logic [35:0] diff;
  logic        fits;
  logic        ovf;

  // quotient needs more than 32 bits: report all ones at once
  assign ovf = !req.is_sqrt && (num[63:32] >= den);

  // one shared subtract serves both the divide and the root step
  always_comb begin
    if (mode_sqrt) begin
      op_a = {rem[32:0], work[63:62]};
      op_b = {1'b0, q, 2'b01};
    end else begin
      op_a = {2'b00, rem[31:0], work[63]};
      op_b = {3'b000, den_r};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    fits = ~diff[35];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (req.start && ovf) || (!req.start && busy && (cnt == 6'd1));
      if (req.start) begin
        mode_sqrt <= req.is_sqrt;
        den_r     <= den;
        cnt       <= 6'(ITER_STEPS);
        if (req.is_sqrt) begin
          q    <= '0;
          rem  <= '0;
          work <= num;
          busy <= 1'b1;
        end else if (ovf) begin
          q    <= '1;
        end else begin
          q    <= '0;
          rem  <= {3'b000, num[63:32]};
          work <= {num[31:0], 32'd0};
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= fits ? diff[34:0] : op_a;
        q    <= {q[30:0], fits};
        work <= mode_sqrt ? {work[61:0], 2'b00} : {work[62:0], 1'b0};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res = q;

endmodule
